// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the rotation matrix core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition in the same cycle as its trigger, on clk, disabled in reset.
`define ERA_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("same-cycle check failed");

// Check a condition in the cycle after its trigger, on clk, disabled in reset.
`define ERA_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/era_pkg.sv =====
// Shared types and constants of the Euler-angle rotation matrix core.
package era_pkg;

  // Angle and output formats.
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int FIELD_W    = 16;
  localparam int OUT_W      = FRAC_BITS + 2;
  localparam int OUT_ONE    = 1 << FRAC_BITS;

  // Pitch and roll scale register, unsigned Q4.12.
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 12;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(4096);

  // Internal trig and product format: Q30 magnitudes up to and including 1.0.
  localparam int Q     = 30;
  localparam int RED_W = Q;
  localparam int MAG_W = Q + 1;

  // Lanes of the trig pipeline.
  localparam int LANES      = 3;
  localparam int LANE_YAW   = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_ROLL  = 2;

  typedef logic [ANGLE_BITS-1:0] angle_t;

  // One input transfer.
  typedef struct packed {
    logic [FIELD_W-1:0] yaw_angle;
    logic [FIELD_W-1:0] pitch_angle;
    logic [FIELD_W-1:0] roll_angle;
  } angles_t;

  // One output transfer.
  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m22;
  } matrix_t;

  // Sign-magnitude Q30 value.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sm_t;

  // Sine and cosine of one angle.
  typedef struct packed {
    sm_t sn;
    sm_t cs;
  } sincos_t;

endpackage

// ===== rtl/core/era_scale.sv =====
// Input stage: applies the pitch and roll scale and registers the three angles.
module era_scale import era_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SCALE_W-1:0]   scale,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  angles_t              angles,
  output logic                 dn_valid,
  input  logic                 dn_stall,
  output angle_t [LANES-1:0]   angle
);

  logic [ANGLE_BITS+SCALE_W-1:0] pitch_prod;
  logic [ANGLE_BITS+SCALE_W-1:0] roll_prod;

  // The stage takes a new transfer unless it holds one that cannot move on.
  assign up_stall = dn_valid && dn_stall;

  // Scale products; the Q4.12 fraction is dropped and the result wraps a turn.
  always_comb begin
    pitch_prod = (ANGLE_BITS+SCALE_W)'(angles.pitch_angle[ANGLE_BITS-1:0]) *
                 (ANGLE_BITS+SCALE_W)'(scale);
    roll_prod  = (ANGLE_BITS+SCALE_W)'(angles.roll_angle[ANGLE_BITS-1:0]) *
                 (ANGLE_BITS+SCALE_W)'(scale);
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!up_stall) begin
      dn_valid <= up_valid;
    end
  end

  // Angle register.
  always_ff @(posedge clk) begin
    if (!up_stall) begin
      angle[LANE_YAW]   <= angles.yaw_angle[ANGLE_BITS-1:0];
      angle[LANE_PITCH] <= pitch_prod[SCALE_FRAC +: ANGLE_BITS];
      angle[LANE_ROLL]  <= roll_prod[SCALE_FRAC +: ANGLE_BITS];
    end
  end

endmodule

// ===== rtl/core/era_trig.sv =====
// Pipelined sine and cosine of three binary angles, as Q30 sign-magnitude values.
module era_trig import era_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  angle_t [LANES-1:0]   angle,
  output logic                 dn_valid,
  input  logic                 dn_stall,
  output sincos_t [LANES-1:0]  sincos
);

  localparam int TRIG_STAGES = 9;

  localparam int EIGHTH = 1 << (ANGLE_BITS - 3);
  localparam logic [31:0]      PI_Q30 = 32'hC90FDAA2;
  localparam logic [MAG_W-1:0] ONE    = MAG_W'(1) << Q;

  // Quadrant codes.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Exact reciprocals for floor division of values below 2^Q by small constants.
  localparam int RSH42 = Q + 6;
  localparam int RSH56 = Q + 6;
  localparam int RSH20 = Q + 5;
  localparam int RSH30 = Q + 5;
  localparam int RSH6  = Q + 3;
  localparam int RSH12 = Q + 4;
  localparam logic [Q:0] RCP42 = (Q+1)'(((64'd1 << RSH42) + 64'd41) / 64'd42);
  localparam logic [Q:0] RCP56 = (Q+1)'(((64'd1 << RSH56) + 64'd55) / 64'd56);
  localparam logic [Q:0] RCP20 = (Q+1)'(((64'd1 << RSH20) + 64'd19) / 64'd20);
  localparam logic [Q:0] RCP30 = (Q+1)'(((64'd1 << RSH30) + 64'd29) / 64'd30);
  localparam logic [Q:0] RCP6  = (Q+1)'(((64'd1 << RSH6) + 64'd5) / 64'd6);
  localparam logic [Q:0] RCP12 = (Q+1)'(((64'd1 << RSH12) + 64'd11) / 64'd12);

  logic [TRIG_STAGES-1:0] vld;
  logic [TRIG_STAGES-1:0] en;
  sincos_t                sc_lane [LANES];

  // Floor division by a constant through its reciprocal.
  function automatic logic [RED_W-1:0] div_const(logic [RED_W-1:0] x, logic [Q:0] m,
                                                 int sh);
    logic [RED_W+Q:0] p;
    p = (RED_W+Q+1)'(x) * (RED_W+Q+1)'(m);
    return RED_W'(p >> sh);
  endfunction

  // Q30 product, truncated.
  function automatic logic [RED_W-1:0] mul_trunc(logic [RED_W-1:0] a, logic [MAG_W-1:0] b);
    logic [RED_W+MAG_W-1:0] p;
    p = (RED_W+MAG_W)'(a) * (RED_W+MAG_W)'(b);
    return p[Q +: RED_W];
  endfunction

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[TRIG_STAGES-1] = !vld[TRIG_STAGES-1] || !dn_stall;
    for (int i = TRIG_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign up_stall = !en[0];
  assign dn_valid = vld[TRIG_STAGES-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= up_valid;
      end
      for (int i = 1; i < TRIG_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [ANGLE_BITS:0]     bias_sum;
    logic [ANGLE_BITS-3:0]   frac;
    logic                    off_neg;
    logic [ANGLE_BITS-3:0]   off_mag;
    logic [ANGLE_BITS+29:0]  rad_prod;
    logic [2*RED_W-1:0]      sq_prod;
    logic [MAG_W-1:0]        cos_mag;
    logic [RED_W-1:0]        y_p  [7];
    logic [RED_W-1:0]        y2_p [1:6];
    logic [7:0]              neg_p;
    logic [1:0]              quad_p [8];
    logic [RED_W-1:0]        sq2, cq2, sp3, cp3, sq4, cq4, sp5, cp5, sq6, cq6, s7, cp7;

    // Reduction to the nearest quarter turn and an offset of at most an eighth.
    always_comb begin
      bias_sum = {1'b0, angle[l]} + (ANGLE_BITS+1)'(EIGHTH);
      frac     = bias_sum[ANGLE_BITS-3:0];
      off_neg  = !bias_sum[ANGLE_BITS-3];
      off_mag  = off_neg ? ((ANGLE_BITS-2)'(EIGHTH) - frac)
                         : (frac - (ANGLE_BITS-2)'(EIGHTH));
      rad_prod = (ANGLE_BITS+30)'(off_mag) * (ANGLE_BITS+30)'(PI_Q30);
      sq_prod  = (2*RED_W)'(y_p[0]) * (2*RED_W)'(y_p[0]);
      cos_mag  = ONE - MAG_W'(cp7 >> 1);
    end

    // Offset in radians, then its square, carried along with sign and quadrant.
    always_ff @(posedge clk) begin
      if (en[0]) begin
        y_p[0]    <= rad_prod[ANGLE_BITS-1 +: RED_W];
        neg_p[0]  <= off_neg;
        quad_p[0] <= bias_sum[ANGLE_BITS-1:ANGLE_BITS-2];
      end
      for (int i = 1; i < 8; i++) begin
        if (en[i]) begin
          neg_p[i]  <= neg_p[i-1];
          quad_p[i] <= quad_p[i-1];
        end
      end
      for (int i = 1; i < 7; i++) begin
        if (en[i]) begin
          y_p[i] <= y_p[i-1];
        end
      end
      if (en[1]) begin
        y2_p[1] <= sq_prod[Q +: RED_W];
      end
      for (int i = 2; i < 7; i++) begin
        if (en[i]) begin
          y2_p[i] <= y2_p[i-1];
        end
      end
    end

    // Horner steps of the sine and cosine series, one divide or multiply a stage.
    always_ff @(posedge clk) begin
      if (en[2]) begin
        sq2 <= div_const(y2_p[1], RCP42, RSH42);
        cq2 <= div_const(y2_p[1], RCP56, RSH56);
      end
      if (en[3]) begin
        sp3 <= mul_trunc(y2_p[2], ONE - MAG_W'(sq2));
        cp3 <= mul_trunc(y2_p[2], ONE - MAG_W'(cq2));
      end
      if (en[4]) begin
        sq4 <= div_const(sp3, RCP20, RSH20);
        cq4 <= div_const(cp3, RCP30, RSH30);
      end
      if (en[5]) begin
        sp5 <= mul_trunc(y2_p[4], ONE - MAG_W'(sq4));
        cp5 <= mul_trunc(y2_p[4], ONE - MAG_W'(cq4));
      end
      if (en[6]) begin
        sq6 <= div_const(sp5, RCP6, RSH6);
        cq6 <= div_const(cp5, RCP12, RSH12);
      end
      if (en[7]) begin
        s7  <= mul_trunc(y_p[6], ONE - MAG_W'(sq6));
        cp7 <= mul_trunc(y2_p[6], ONE - MAG_W'(cq6));
      end
    end

    // Quadrant swap and sign.
    always_ff @(posedge clk) begin
      if (en[8]) begin
        case (quad_p[7])
          QUAD_0: begin
            sc_lane[l].sn <= '{neg_p[7], MAG_W'(s7)};
            sc_lane[l].cs <= '{1'b0, cos_mag};
          end
          QUAD_1: begin
            sc_lane[l].sn <= '{1'b0, cos_mag};
            sc_lane[l].cs <= '{!neg_p[7], MAG_W'(s7)};
          end
          QUAD_2: begin
            sc_lane[l].sn <= '{!neg_p[7], MAG_W'(s7)};
            sc_lane[l].cs <= '{1'b1, cos_mag};
          end
          QUAD_3: begin
            sc_lane[l].sn <= '{1'b1, cos_mag};
            sc_lane[l].cs <= '{neg_p[7], MAG_W'(s7)};
          end
          default: begin
            sc_lane[l] <= '0;
          end
        endcase
      end
    end
  end

  // Collect the lanes on the output.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sincos[l] = sc_lane[l];
    end
  end

endmodule

// ===== rtl/core/era_matrix.sv =====
// Pipelined products, sums and output rounding of the nine matrix elements.
module era_matrix import era_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  sincos_t [LANES-1:0]  sincos,
  output logic                 dn_valid,
  input  logic                 dn_stall,
  output matrix_t              matrix
);

  localparam int MAT_STAGES = 4;
  localparam int SUM_W      = Q + 3;
  localparam int ROUND_SH   = Q - FRAC_BITS;

  logic [MAT_STAGES-1:0] vld;
  logic [MAT_STAGES-1:0] en;
  sincos_t               a, b, c;

  // First products and carried factors.
  sm_t sasb, casb, p00, p01, p12, p22, casc, cacc, sasc, sacc, sb0, sc0, cc0;
  // Second products and carried first products.
  sm_t r10, r11, r20, r21, p00_1, p01_1, p12_1, p22_1, casc_1, cacc_1, sasc_1, sacc_1, sb1;
  // Signed sums ahead of rounding.
  logic signed [SUM_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;

  // Q30 product of sign-magnitude values, rounded half away from zero.
  function automatic sm_t sm_mul(sm_t x, sm_t y);
    logic [2*MAG_W-1:0] p;
    p = (2*MAG_W)'(x.mag) * (2*MAG_W)'(y.mag) + ((2*MAG_W)'(1) << (Q - 1));
    return '{x.neg ^ y.neg, p[Q +: MAG_W]};
  endfunction

  // Sign-magnitude to two's complement.
  function automatic logic signed [SUM_W-1:0] sm_to_s(sm_t x);
    logic signed [SUM_W-1:0] ext;
    ext = SUM_W'(x.mag);
    return x.neg ? -ext : ext;
  endfunction

  // Round to the output fraction, half away from zero, and clamp to plus or minus one.
  function automatic logic signed [OUT_W-1:0] to_out(logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] rnd;
    mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    rnd = (mag + (SUM_W'(1) << (ROUND_SH - 1))) >> ROUND_SH;
    if (rnd > SUM_W'(OUT_ONE)) begin
      rnd = SUM_W'(OUT_ONE);
    end
    return v[SUM_W-1] ? OUT_W'(-rnd) : OUT_W'(rnd);
  endfunction

  assign a = sincos[LANE_YAW];
  assign b = sincos[LANE_PITCH];
  assign c = sincos[LANE_ROLL];

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[MAT_STAGES-1] = !vld[MAT_STAGES-1] || !dn_stall;
    for (int i = MAT_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign up_stall = !en[0];
  assign dn_valid = vld[MAT_STAGES-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= up_valid;
      end
      for (int i = 1; i < MAT_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Products of two factors.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sasb <= sm_mul(a.sn, b.sn);
      casb <= sm_mul(a.cs, b.sn);
      p00  <= sm_mul(b.cs, c.cs);
      p01  <= sm_mul(b.cs, c.sn);
      p12  <= sm_mul(a.sn, b.cs);
      p22  <= sm_mul(a.cs, b.cs);
      casc <= sm_mul(a.cs, c.sn);
      cacc <= sm_mul(a.cs, c.cs);
      sasc <= sm_mul(a.sn, c.sn);
      sacc <= sm_mul(a.sn, c.cs);
      sb0  <= b.sn;
      sc0  <= c.sn;
      cc0  <= c.cs;
    end
  end

  // Triple products, formed from the yaw-pitch products.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      r10    <= sm_mul(sasb, cc0);
      r11    <= sm_mul(sasb, sc0);
      r20    <= sm_mul(casb, cc0);
      r21    <= sm_mul(casb, sc0);
      p00_1  <= p00;
      p01_1  <= p01;
      p12_1  <= p12;
      p22_1  <= p22;
      casc_1 <= casc;
      cacc_1 <= cacc;
      sasc_1 <= sasc;
      sacc_1 <= sacc;
      sb1    <= sb0;
    end
  end

  // Element sums in two's complement.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      e00 <= sm_to_s(p00_1);
      e01 <= sm_to_s(p01_1);
      e02 <= sm_to_s(sm_t'{!sb1.neg, sb1.mag});
      e10 <= sm_to_s(r10) - sm_to_s(casc_1);
      e11 <= sm_to_s(r11) + sm_to_s(cacc_1);
      e12 <= sm_to_s(p12_1);
      e20 <= sm_to_s(r20) + sm_to_s(sasc_1);
      e21 <= sm_to_s(r21) - sm_to_s(sacc_1);
      e22 <= sm_to_s(p22_1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      matrix.m00 <= to_out(e00);
      matrix.m01 <= to_out(e01);
      matrix.m02 <= to_out(e02);
      matrix.m10 <= to_out(e10);
      matrix.m11 <= to_out(e11);
      matrix.m12 <= to_out(e12);
      matrix.m20 <= to_out(e20);
      matrix.m21 <= to_out(e21);
      matrix.m22 <= to_out(e22);
    end
  end

endmodule

// ===== rtl/core/euler_angles_to_rotation_matrix_core.sv =====
// Top level of the Euler-angle to 3x3 rotation matrix core.
// Takes yaw, pitch and roll as binary angles (a full turn is 65536) and returns the
// nine elements of the rotation matrix as signed Q1.14 values, clamped to plus or
// minus one. Pitch and roll are multiplied by the Q4.12 value last written on
// cfg_we/cfg_wdata (1.0 after reset) and wrap modulo one turn. The core accepts one
// angle transfer per clock and returns one matrix transfer per clock while
// matrix_stall is low; a result passes through the scale multiply, the sine and
// cosine series and the products, sums and rounding, in that order.
// Each pipeline stage loads whenever it is empty or its successor moves on, so
// angles keep being accepted while a result waits on matrix_stall, until every
// stage is full. Write the scale register only while the core is empty.
`include "assert_macros.svh"

module euler_angles_to_rotation_matrix_core import era_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               angle_valid,
  output logic               angle_stall,
  input  angles_t            angles,
  output logic               matrix_valid,
  input  logic               matrix_stall,
  output matrix_t            matrix,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_wdata
);

  logic [SCALE_W-1:0]  scale;
  logic                scl_valid;
  logic                scl_stall;
  angle_t [LANES-1:0]  scl_angle;
  logic                trig_valid;
  logic                trig_stall;
  sincos_t [LANES-1:0] sincos;

  // Pitch and roll scale register.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_we) begin
      scale <= cfg_wdata;
    end
  end

  // Angle scaling.
  era_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .scale    (scale),
    .up_valid (angle_valid),
    .up_stall (angle_stall),
    .angles   (angles),
    .dn_valid (scl_valid),
    .dn_stall (scl_stall),
    .angle    (scl_angle)
  );

  // Sines and cosines of the three angles.
  era_trig u_trig (
    .clk      (clk),
    .rst      (rst),
    .up_valid (scl_valid),
    .up_stall (scl_stall),
    .angle    (scl_angle),
    .dn_valid (trig_valid),
    .dn_stall (trig_stall),
    .sincos   (sincos)
  );

  // Matrix elements.
  era_matrix u_matrix (
    .clk      (clk),
    .rst      (rst),
    .up_valid (trig_valid),
    .up_stall (trig_stall),
    .sincos   (sincos),
    .dn_valid (matrix_valid),
    .dn_stall (matrix_stall),
    .matrix   (matrix)
  );

  // A configuration write lands in the scale register on the next cycle.
  `ERA_ASSERT_NEXT(a_cfg_write, cfg_we, scale == $past(cfg_wdata))
  // Input transfers are held off only when the scale stage holds an item.
  `ERA_ASSERT_NOW(a_stall_full, angle_stall, scl_valid)
  // A summed element stays within plus or minus one after saturation.
  `ERA_ASSERT_NOW(a_m11_range, matrix_valid, (matrix.m11 <= OUT_ONE) && (matrix.m11 >= -OUT_ONE))
  // Reset empties the pipeline.
  `ERA_ASSERT_NOW(a_reset_empty, $past(rst), !matrix_valid)

endmodule
